@@ rtl/pslp_pkg.sv @@
// Package for the priority status LED pattern block.
// Holds item, command and state types, timing constants and the small
// arithmetic helpers. Depends on nothing.
package pslp_pkg;

  localparam int unsigned MS_W = 11;
  localparam int unsigned RV_W = 5;
  localparam int unsigned FC_W = 4;

  localparam logic [MS_W-1:0] ERR_ON_MS    = 11'd100;
  localparam logic [MS_W-1:0] ERR_OFF_MS   = 11'd250;
  localparam logic [MS_W-1:0] ERR_PAUSE_MS = 11'd1250;

  // unused effect code, stored as off
  localparam logic [1:0] EFFECT_RSVD = 2'd3;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_BLINK = 2'd1,
    MODE_ERROR = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SELECT,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_t       req_type;
    logic [1:0] slot;
    logic [1:0] effect_mode;
    logic [7:0] effect_value;
  } in_item_t;

  typedef struct packed {
    logic       led_pin;
    logic       led_lit;
    logic [1:0] active_mode;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic tick_count;
    logic tick_expire;
    logic table_write;
    logic select;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic req_tick;
    logic expire;
    logic found;
  } sts_t;

  function automatic logic [RV_W-1:0] mod17(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd136) t = t - 8'd136;
    if (t >= 8'd68)  t = t - 8'd68;
    if (t >= 8'd34)  t = t - 8'd34;
    if (t >= 8'd17)  t = t - 8'd17;
    return t[RV_W-1:0];
  endfunction

  function automatic logic [RV_W-1:0] mod11(input logic [7:0] v);
    logic [8:0] t;
    t = {1'b0, v};
    if (t >= 9'd176) t = t - 9'd176;
    if (t >= 9'd88)  t = t - 9'd88;
    if (t >= 9'd44)  t = t - 9'd44;
    if (t >= 9'd22)  t = t - 9'd22;
    if (t >= 9'd11)  t = t - 9'd11;
    return t[RV_W-1:0];
  endfunction

  // (1000 / rate) / 2 for rate 1..16
  function automatic logic [MS_W-1:0] blink_half(input logic [RV_W-1:0] r);
    logic [MS_W-1:0] h;
    unique case (r)
      5'd2:    h = 11'd250;
      5'd3:    h = 11'd166;
      5'd4:    h = 11'd125;
      5'd5:    h = 11'd100;
      5'd6:    h = 11'd83;
      5'd7:    h = 11'd71;
      5'd8:    h = 11'd62;
      5'd9:    h = 11'd55;
      5'd10:   h = 11'd50;
      5'd11:   h = 11'd45;
      5'd12:   h = 11'd41;
      5'd13:   h = 11'd38;
      5'd14:   h = 11'd35;
      5'd15:   h = 11'd33;
      5'd16:   h = 11'd31;
      default: h = 11'd500;
    endcase
    return h;
  endfunction

endpackage

@@ rtl/pslp_ctrl.sv @@
// Controller state machine for the priority status LED pattern block.
// Sequences capture, table update, selection, pattern step and result load.
// Depends on pslp_pkg.
module pslp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  pslp_pkg::sts_t sts,
  output pslp_pkg::cmd_t cmd
);

  pslp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pslp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      pslp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = pslp_pkg::ST_APPLY;
        end
      end
      pslp_pkg::ST_APPLY: begin
        if (sts.req_tick) begin
          if (sts.expire) begin
            cmd.tick_expire = 1'b1;
            state_nxt       = pslp_pkg::ST_STEP;
          end else begin
            cmd.tick_count = 1'b1;
            state_nxt      = pslp_pkg::ST_DONE;
          end
        end else begin
          cmd.table_write = 1'b1;
          state_nxt       = pslp_pkg::ST_SELECT;
        end
      end
      pslp_pkg::ST_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = sts.found ? pslp_pkg::ST_STEP : pslp_pkg::ST_DONE;
      end
      pslp_pkg::ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = pslp_pkg::ST_DONE;
      end
      pslp_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = pslp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pslp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/pslp_dp.sv @@
// Datapath for the priority status LED pattern block: slot table, running
// effect, flash counter, millisecond timer and result register.
// Depends on pslp_pkg.
module pslp_dp #(
  parameter int unsigned TASK_SLOTS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pslp_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  pslp_pkg::cmd_t      cmd,
  output pslp_pkg::sts_t      sts,
  output pslp_pkg::out_item_t out_item
);

  logic [1:0]                  modes_r   [TASK_SLOTS];
  logic [1:0]                  modes_nxt [TASK_SLOTS];
  logic [7:0]                  values_r  [TASK_SLOTS];
  logic [7:0]                  values_nxt[TASK_SLOTS];
  pslp_pkg::mode_t             run_mode_r, run_mode_nxt;
  logic [pslp_pkg::RV_W-1:0]   run_value_r, run_value_nxt;
  logic [pslp_pkg::FC_W-1:0]   flash_r, flash_nxt;
  logic                        lit_r, lit_nxt;
  logic [pslp_pkg::MS_W-1:0]   ms_left_r, ms_left_nxt;
  logic                        armed_r, armed_nxt;
  logic                        inv_r;
  pslp_pkg::in_item_t          item_r;
  pslp_pkg::out_item_t         out_r;

  logic                        sel_found;
  logic [1:0]                  sel_mode;
  logic [7:0]                  sel_value;
  logic [pslp_pkg::RV_W-1:0]   sel_red;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
        modes_r[k]  <= pslp_pkg::MODE_OFF;
        values_r[k] <= 8'd0;
      end
      run_mode_r  <= pslp_pkg::MODE_OFF;
      run_value_r <= '0;
      flash_r     <= '0;
      lit_r       <= 1'b0;
      ms_left_r   <= '0;
      armed_r     <= 1'b0;
      inv_r       <= 1'b0;
    end else begin
      modes_r     <= modes_nxt;
      values_r    <= values_nxt;
      run_mode_r  <= run_mode_nxt;
      run_value_r <= run_value_nxt;
      flash_r     <= flash_nxt;
      lit_r       <= lit_nxt;
      ms_left_r   <= ms_left_nxt;
      armed_r     <= armed_nxt;
      if (cfg_we) inv_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.load_out) out_r <= '{led_pin: lit_r ^ inv_r, led_lit: lit_r,
                                 active_mode: run_mode_r};
  end

  // lowest-numbered active slot wins
  always_comb begin
    sel_found = 1'b0;
    sel_mode  = pslp_pkg::MODE_OFF;
    sel_value = 8'd0;
    for (int k = TASK_SLOTS - 1; k >= 0; k--) begin
      if (modes_r[k] != pslp_pkg::MODE_OFF) begin
        sel_found = 1'b1;
        sel_mode  = modes_r[k];
        sel_value = values_r[k];
      end
    end
    sel_red = (sel_mode == pslp_pkg::MODE_BLINK) ? pslp_pkg::mod17(sel_value)
                                                 : pslp_pkg::mod11(sel_value);
    if (sel_red == '0) sel_red = 5'd1;
  end

  always_comb begin
    modes_nxt     = modes_r;
    values_nxt    = values_r;
    run_mode_nxt  = run_mode_r;
    run_value_nxt = run_value_r;
    flash_nxt     = flash_r;
    lit_nxt       = lit_r;
    ms_left_nxt   = ms_left_r;
    armed_nxt     = armed_r;

    if (cmd.table_write) begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
        priority if (item_r.req_type == pslp_pkg::REQ_CLEAR) begin
          modes_nxt[k]  = pslp_pkg::MODE_OFF;
          values_nxt[k] = 8'd0;
        end else if (int'(item_r.slot) == k) begin
          if (item_r.req_type == pslp_pkg::REQ_ADD) begin
            modes_nxt[k]  = (item_r.effect_mode == pslp_pkg::EFFECT_RSVD)
                            ? pslp_pkg::MODE_OFF : item_r.effect_mode;
            values_nxt[k] = item_r.effect_value;
          end else begin
            modes_nxt[k]  = pslp_pkg::MODE_OFF;
            values_nxt[k] = 8'd0;
          end
        end
      end
    end

    if (cmd.tick_count && armed_r) begin
      ms_left_nxt = ms_left_r - 11'd1;
    end

    if (cmd.tick_expire) begin
      armed_nxt   = 1'b0;
      ms_left_nxt = '0;
    end

    if (cmd.select) begin
      lit_nxt       = 1'b0;
      armed_nxt     = 1'b0;
      ms_left_nxt   = '0;
      flash_nxt     = '0;
      run_mode_nxt  = sel_found ? pslp_pkg::mode_t'(sel_mode) : pslp_pkg::MODE_OFF;
      run_value_nxt = sel_found ? sel_red : '0;
    end

    if (cmd.step) begin
      unique case (run_mode_r)
        pslp_pkg::MODE_BLINK: begin
          lit_nxt     = ~lit_r;
          ms_left_nxt = pslp_pkg::blink_half(run_value_r);
          armed_nxt   = 1'b1;
        end
        pslp_pkg::MODE_ERROR: begin
          armed_nxt = 1'b1;
          priority if (!lit_r && ({1'b0, flash_r} < run_value_r)) begin
            lit_nxt     = 1'b1;
            flash_nxt   = flash_r + 4'd1;
            ms_left_nxt = pslp_pkg::ERR_ON_MS;
          end else if (lit_r && ({1'b0, flash_r} <= run_value_r)) begin
            lit_nxt     = 1'b0;
            ms_left_nxt = pslp_pkg::ERR_OFF_MS;
          end else begin
            flash_nxt   = '0;
            lit_nxt     = 1'b0;
            ms_left_nxt = pslp_pkg::ERR_PAUSE_MS;
          end
        end
        default: begin
          lit_nxt     = 1'b0;
          armed_nxt   = 1'b0;
          ms_left_nxt = '0;
        end
      endcase
    end
  end

  assign sts.req_tick = (item_r.req_type == pslp_pkg::REQ_TICK);
  assign sts.expire   = armed_r && (ms_left_r <= 11'd1);
  assign sts.found    = sel_found;
  assign out_item     = out_r;

endmodule

@@ rtl/priority_status_led_pattern.sv @@
// Priority status LED pattern generator, top level.
// Input channel in_valid/in_ready/in_item carries one request per item:
// a millisecond tick, or an add, remove or clear-all on the four-slot
// effect table (slot 0 is highest priority). Output channel
// out_valid/out_ready/out_item returns one result per item: pin level,
// lit state and the effect now running. cfg_we/cfg_wdata set the LED
// inversion; write it only while the block is idle.
// Sequence: a tick goes through apply and load when the timer does not
// expire, and through apply, pattern step and load when it does; a table
// request goes through apply, select, pattern step (only when an effect
// is found) and load. One item is in work at a time.
// A new item is taken while the previous result still waits in the output
// register; if the receiver stalls, the next result holds in the done state
// and input stops being accepted until the register frees up.
// Reset (synchronous, rst_n low) clears the table, the running effect, the
// timer, the inversion setting and the output valid.
// Depends on pslp_pkg, pslp_ctrl and pslp_dp.
module priority_status_led_pattern #(
  parameter int unsigned TASK_SLOTS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pslp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output pslp_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  pslp_pkg::cmd_t cmd;
  pslp_pkg::sts_t sts;

  pslp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pslp_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule
